[rtl/mac_frame_header_parser_macros.svh]
// assertion macros for the mac frame header parser
`ifndef MAC_FRAME_HEADER_PARSER_MACROS_SVH
`define MAC_FRAME_HEADER_PARSER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked at every rising edge out of reset
`define MFHP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MFHP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MFHP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MFHP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/mfhp_pkg.sv]
// constants, result type and field helpers for the mac frame header parser
package mfhp_pkg;

  localparam logic [6:0] MAX_FRAME_BYTES = 7'd127;

  // parse phases, which double as the field kind codes
  localparam logic [3:0] PH_FCTL    = 4'd0;
  localparam logic [3:0] PH_SEQ     = 4'd1;
  localparam logic [3:0] PH_DPAN    = 4'd2;
  localparam logic [3:0] PH_DADDR   = 4'd3;
  localparam logic [3:0] PH_SPAN    = 4'd4;
  localparam logic [3:0] PH_SADDR   = 4'd5;
  localparam logic [3:0] PH_SECCTL  = 4'd6;
  localparam logic [3:0] PH_COUNTER = 4'd7;
  localparam logic [3:0] PH_KEYSRC  = 4'd8;
  localparam logic [3:0] PH_KEYIDX  = 4'd9;
  localparam logic [3:0] PH_TRAIL   = 4'd10;
  localparam logic [3:0] KIND_FCS   = 4'd11;
  localparam logic [3:0] KIND_LQI   = 4'd12;
  localparam logic [3:0] KIND_RSSI  = 4'd13;
  localparam logic [3:0] PH_DISCARD = 4'd14;
  localparam logic [3:0] PH_IDLE    = 4'd15;

  // address modes
  localparam logic [1:0] AMODE_NONE  = 2'd0;
  localparam logic [1:0] AMODE_RSVD  = 2'd1;
  localparam logic [1:0] AMODE_LONG  = 2'd3;

  // key identifier modes
  localparam logic [1:0] KMODE_NONE  = 2'd0;
  localparam logic [1:0] KMODE_INDEX = 2'd1;
  localparam logic [1:0] KMODE_SRC8  = 2'd3;

  typedef struct packed {
    logic [3:0] field_kind;
    logic [2:0] byte_index;
    logic [7:0] data_out;
    logic       src_pan_from_dst;
    logic       frame_end;
    logic       parse_error;
  } res_t;

  function automatic logic [1:0] dst_mode(input logic [15:0] cw);
    return cw[11:10];
  endfunction

  function automatic logic [1:0] src_mode(input logic [15:0] cw);
    return cw[15:14];
  endfunction

  function automatic logic [1:0] key_mode(input logic [7:0] sc);
    return sc[4:3];
  endfunction

  function automatic logic pan_compressed(input logic [15:0] cw);
    return cw[6] && (dst_mode(cw) != AMODE_NONE) && (src_mode(cw) != AMODE_NONE);
  endfunction

  // bytes in the field of a header phase
  function automatic logic [3:0] field_len(input logic [3:0] p, input logic [15:0] cw,
                                           input logic [7:0] sc);
    logic [3:0] n;
    n = 4'd1;
    case (p)
      PH_FCTL:    n = 4'd2;
      PH_DPAN:    n = 4'd2;
      PH_DADDR:   n = (dst_mode(cw) == AMODE_LONG) ? 4'd8 : 4'd2;
      PH_SPAN:    n = 4'd2;
      PH_SADDR:   n = (src_mode(cw) == AMODE_LONG) ? 4'd8 : 4'd2;
      PH_COUNTER: n = 4'd4;
      PH_KEYSRC:  n = (key_mode(sc) == KMODE_SRC8) ? 4'd8 : 4'd4;
      default:    n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] after_src(input logic [15:0] cw, input logic sec_en);
    return (cw[3] && sec_en) ? PH_SECCTL : PH_TRAIL;
  endfunction

  function automatic logic [3:0] after_dst(input logic [15:0] cw, input logic sec_en);
    logic [3:0] n;
    if (src_mode(cw) != AMODE_NONE) begin
      n = pan_compressed(cw) ? PH_SADDR : PH_SPAN;
    end else begin
      n = after_src(cw, sec_en);
    end
    return n;
  endfunction

  // phase that follows a completed header field
  function automatic logic [3:0] next_phase(input logic [3:0] p, input logic [15:0] cw,
                                            input logic [7:0] sc, input logic sec_en);
    logic [3:0] n;
    n = PH_TRAIL;
    case (p)
      PH_FCTL:    n = PH_SEQ;
      PH_SEQ:     n = (dst_mode(cw) != AMODE_NONE) ? PH_DPAN : after_dst(cw, sec_en);
      PH_DPAN:    n = PH_DADDR;
      PH_DADDR:   n = after_dst(cw, sec_en);
      PH_SPAN:    n = PH_SADDR;
      PH_SADDR:   n = after_src(cw, sec_en);
      PH_SECCTL:  n = PH_COUNTER;
      PH_COUNTER: begin
        if (key_mode(sc) == KMODE_NONE) begin
          n = PH_TRAIL;
        end else if (key_mode(sc) == KMODE_INDEX) begin
          n = PH_KEYIDX;
        end else begin
          n = PH_KEYSRC;
        end
      end
      PH_KEYSRC:  n = PH_KEYIDX;
      default:    n = PH_TRAIL;
    endcase
    return n;
  endfunction

endpackage

[rtl/mac_frame_header_parser.sv]
// mac frame header parser top level: byte tagger with input and result registers
//
// Tags each received 802.15.4 frame byte with the MAC field it belongs to:
// frame control, sequence number, destination PAN/address, source PAN/address,
// the optional auxiliary security header (control, frame counter, key source,
// key index), payload, FCS and the LQI and RSSI bytes the radio appends. A
// transfer with frame_start set opens a new frame (also in mid-frame) and
// carries the MPDU length including FCS, so a frame spans frame_length + 2
// transfers. Every input transfer yields exactly one output transfer. Bytes
// arriving outside a frame are tagged discarded with parse_error holding the
// status of the last frame; the rest of a frame after a reserved address
// mode or a header running into the FCS is tagged discarded with parse_error
// high. security_header_enable selects whether the auxiliary
// security header is parsed when the frame control security bit is set; write
// it only while no transfers are in flight. Throughput is one byte per clock
// while the receiver takes every output: the only loop is the parse state update,
// one short step per byte. Each byte passes the input register, then the tag
// logic into the result register; both stages stall on backpressure.
module mac_frame_header_parser (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata,          // security_header_enable
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,       // [7:0] data_byte, [14:8] frame_length, [15] zero
  input  logic        s_axis_tuser,       // frame_start
  // tagged byte output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,       // [2:0] byte_index, [10:3] data_out,
                                          // [11] src_pan_from_dst, [12] parse_error, zeros
  output logic [3:0]  m_axis_tuser,       // field_kind
  output logic        m_axis_tlast        // frame_end
);
  import mfhp_pkg::*;

  `include "mac_frame_header_parser_macros.svh"

  // configuration register
  logic        sec_en;

  // input register
  logic        in_valid;
  logic [7:0]  in_data;
  logic        in_start;
  logic [6:0]  in_len;

  // parse state
  logic [3:0]  phase;
  logic [2:0]  fbc;
  logic [15:0] cw;
  logic [7:0]  sc;
  logic [7:0]  rem;
  logic        err;

  logic [3:0]  phase_next;
  logic [2:0]  fbc_next;
  logic [15:0] cw_next;
  logic [7:0]  sc_next;
  logic [7:0]  rem_next;
  logic        err_next;

  // result register
  logic        out_valid;
  res_t        res;
  res_t        res_next;

  logic        out_adv;
  logic        step;

  // result stage moves when empty or drained this cycle
  assign out_adv       = !out_valid || m_axis_tready;
  assign step          = in_valid && out_adv;
  assign s_axis_tready = !in_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_en <= 1'b0;
    end else if (cfg_we) begin
      sec_en <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data  <= s_axis_tdata[7:0];
      in_len   <= s_axis_tdata[14:8];
      in_start <= s_axis_tuser;
    end
  end

  // tag logic: one step of the parse state per byte
  always_comb begin
    logic [6:0] len_sat;
    logic [3:0] p;
    logic [2:0] c;
    logic [7:0] r;
    logic       first_fctl;
    len_sat    = in_len;
    p          = PH_IDLE;
    c          = 3'd0;
    r          = 8'd0;
    first_fctl = 1'b0;

    phase_next = phase;
    fbc_next   = fbc;
    cw_next    = cw;
    sc_next    = sc;
    rem_next   = rem;
    err_next   = err;

    res_next                  = '0;
    res_next.field_kind       = PH_DISCARD;
    res_next.data_out         = in_data;

    // a frame start resets the parse, even in mid-frame
    if (in_start) begin
      if (in_len > MAX_FRAME_BYTES) begin
        len_sat = MAX_FRAME_BYTES;
      end
      rem_next   = {1'b0, len_sat} + 8'd2;
      phase_next = PH_FCTL;
      fbc_next   = 3'd0;
      cw_next    = 16'd0;
      sc_next    = 8'd0;
      err_next   = 1'b0;
    end
    r = rem_next;

    if (phase_next == PH_IDLE || r == 8'd0) begin
      phase_next = PH_IDLE;
    end else begin
      p          = phase_next;
      c          = fbc_next;
      first_fctl = (p == PH_FCTL) && (c == 3'd0);
      if (p == PH_DISCARD) begin
        res_next.field_kind = PH_DISCARD;
      end else if (p < PH_TRAIL) begin
        if (r <= 8'd4) begin
          // header reaches into fcs/lqi/rssi
          err_next   = 1'b1;
          phase_next = PH_DISCARD;
        end else begin
          res_next.field_kind = p;
          res_next.byte_index = c;
          if (p == PH_FCTL) begin
            if (c == 3'd0) begin
              cw_next = {8'h00, in_data};
            end else begin
              cw_next = {in_data, cw_next[7:0]};
            end
          end
          if (p == PH_SECCTL) begin
            sc_next = in_data;
          end
          if ({1'b0, c} + 4'd1 >= field_len(p, cw_next, sc_next)) begin
            fbc_next   = 3'd0;
            phase_next = next_phase(p, cw_next, sc_next, sec_en);
            if (p == PH_FCTL && (dst_mode(cw_next) == AMODE_RSVD ||
                                 src_mode(cw_next) == AMODE_RSVD)) begin
              err_next   = 1'b1;
              phase_next = PH_DISCARD;
            end
          end else begin
            fbc_next = c + 3'd1;
          end
        end
      end else begin
        // payload, then fcs, lqi, rssi counted from the frame end
        if (r > 8'd4) begin
          res_next.field_kind = PH_TRAIL;
          res_next.byte_index = c;
          fbc_next            = c + 3'd1;
        end else if (r > 8'd2) begin
          res_next.field_kind = KIND_FCS;
          res_next.byte_index = 3'd4 - r[2:0];
        end else if (r == 8'd2) begin
          res_next.field_kind = KIND_LQI;
        end else begin
          res_next.field_kind = KIND_RSSI;
        end
      end
      if (!first_fctl && !err_next && pan_compressed(cw_next)) begin
        res_next.src_pan_from_dst = 1'b1;
      end
      if (r == 8'd1) begin
        res_next.frame_end = 1'b1;
        phase_next         = PH_IDLE;
      end
      rem_next = r - 8'd1;
    end
    res_next.parse_error = err_next;
  end

  // parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      fbc   <= 3'd0;
      cw    <= 16'd0;
      sc    <= 8'd0;
      rem   <= 8'd0;
      err   <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      fbc   <= fbc_next;
      cw    <= cw_next;
      sc    <= sc_next;
      rem   <= rem_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = res.field_kind;
  assign m_axis_tlast  = res.frame_end;
  assign m_axis_tdata  = {3'b000, res.parse_error, res.src_pan_from_dst,
                          res.data_out, res.byte_index};

  // checks
  `MFHP_ASSERT_IMP(a_idle_when_empty, clk, rst, rem == 8'd0, phase == PH_IDLE, "frame count empty outside idle")
  `MFHP_ASSERT_IMP(a_no_tail_phase, clk, rst, 1'b1, phase != KIND_FCS && phase != KIND_LQI && phase != KIND_RSSI, "tail kind held as parse phase")
  `MFHP_ASSERT_IMP(a_end_kind, clk, rst, out_valid && res.frame_end, res.field_kind == KIND_RSSI || res.field_kind == PH_DISCARD, "frame end on wrong field")
  `MFHP_ASSERT_IMP(a_flag_excl, clk, rst, out_valid, !(res.src_pan_from_dst && res.parse_error), "pan copy flag with error")
  `MFHP_ASSERT_NXT(a_end_idle, clk, rst, step && res_next.frame_end && !in_start, phase == PH_IDLE, "frame end left parser busy")

endmodule

[test/byte_tag_checker.sv]
// checker that predicts the field tag of every accepted frame byte and compares it
`timescale 1ns / 1ps
module byte_tag_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [3:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          outstanding
);
  import mfhp_pkg::*;

  // parser state as the block should hold it
  logic [3:0] phase;
  logic [2:0] fcount;
  logic [15:0] fc_word;
  logic [7:0] sec_ctl;
  logic [7:0] left;
  logic       err_flag;
  logic       sec_en;

  res_t tags_due[$];

  function automatic int addr_bytes(input logic [1:0] mode);
    return (mode == AMODE_LONG) ? 8 : 2;
  endfunction

  function automatic bit pan_shared(input logic [15:0] fc);
    return fc[6] && (fc[11:10] != AMODE_NONE) && (fc[15:14] != AMODE_NONE);
  endfunction

  function automatic int field_bytes(input logic [3:0] p);
    case (p)
      PH_FCTL, PH_DPAN, PH_SPAN: return 2;
      PH_DADDR: return addr_bytes(fc_word[11:10]);
      PH_SADDR: return addr_bytes(fc_word[15:14]);
      PH_COUNTER: return 4;
      PH_KEYSRC: return (sec_ctl[4:3] == KMODE_SRC8) ? 8 : 4;
      default: return 1;
    endcase
  endfunction

  function automatic logic [3:0] after_source();
    return (fc_word[3] && sec_en) ? PH_SECCTL : PH_TRAIL;
  endfunction

  function automatic logic [3:0] after_dest();
    if (fc_word[15:14] == AMODE_NONE) return after_source();
    return pan_shared(fc_word) ? PH_SADDR : PH_SPAN;
  endfunction

  function automatic logic [3:0] following(input logic [3:0] p);
    case (p)
      PH_FCTL: return PH_SEQ;
      PH_SEQ: return (fc_word[11:10] != AMODE_NONE) ? PH_DPAN : after_dest();
      PH_DPAN: return PH_DADDR;
      PH_DADDR: return after_dest();
      PH_SPAN: return PH_SADDR;
      PH_SADDR: return after_source();
      PH_SECCTL: return PH_COUNTER;
      PH_COUNTER: begin
        if (sec_ctl[4:3] == KMODE_NONE) return PH_TRAIL;
        return (sec_ctl[4:3] == KMODE_INDEX) ? PH_KEYIDX : PH_KEYSRC;
      end
      PH_KEYSRC: return PH_KEYIDX;
      default: return PH_TRAIL;
    endcase
  endfunction

  // advance the parser by one byte and return its tag
  task automatic tag_byte(input logic [7:0] b, input logic start, input logic [6:0] flen,
                          output res_t t);
    logic [3:0] p;
    logic [7:0] r;
    logic [2:0] c;
    bit first;
    t = '0;
    t.field_kind = PH_DISCARD;
    t.data_out = b;
    if (start) begin
      left = ((flen > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : flen) + 8'd2;
      phase = PH_FCTL;
      fcount = '0;
      fc_word = '0;
      sec_ctl = '0;
      err_flag = 1'b0;
    end
    r = left;
    if (phase == PH_IDLE || r == 0) begin
      phase = PH_IDLE;
    end else begin
      p = phase;
      first = (p == PH_FCTL) && (fcount == 0);
      if (p < PH_TRAIL) begin
        if (r <= 4) begin
          // header runs into fcs, lqi and rssi
          err_flag = 1'b1;
          phase = PH_DISCARD;
        end else begin
          c = fcount;
          t.field_kind = p;
          t.byte_index = c;
          if (p == PH_FCTL) fc_word = (c == 0) ? {8'h00, b} : {b, fc_word[7:0]};
          if (p == PH_SECCTL) sec_ctl = b;
          if (c + 1 >= field_bytes(p)) begin
            fcount = '0;
            phase = following(p);
            if (p == PH_FCTL && (fc_word[11:10] == AMODE_RSVD ||
                                 fc_word[15:14] == AMODE_RSVD)) begin
              err_flag = 1'b1;
              phase = PH_DISCARD;
            end
          end else begin
            fcount = c + 3'd1;
          end
        end
      end else if (p != PH_DISCARD) begin
        if (r > 4) begin
          t.field_kind = PH_TRAIL;
          t.byte_index = fcount;
          fcount = fcount + 3'd1;
        end else if (r > 2) begin
          t.field_kind = KIND_FCS;
          t.byte_index = 3'(8'd4 - r);
        end else if (r == 2) begin
          t.field_kind = KIND_LQI;
        end else begin
          t.field_kind = KIND_RSSI;
        end
      end
      t.src_pan_from_dst = !first && !err_flag && pan_shared(fc_word);
      if (r == 1) begin
        t.frame_end = 1'b1;
        phase = PH_IDLE;
      end
      left = r - 8'd1;
    end
    t.parse_error = err_flag;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      phase = PH_IDLE;
      fcount = '0;
      fc_word = '0;
      sec_ctl = '0;
      left = '0;
      err_flag = 1'b0;
      sec_en = 1'b0;
      mismatches = 0;
      tags_due.delete();
    end else begin
      if (cfg_we) sec_en = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        tag_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[14:8], want);
        tags_due.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (tags_due.size() == 0) begin
          $error("output transfer with no byte pending: kind %0d tdata %h",
                 m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = tags_due.pop_front();
          check_field("field_kind", want.field_kind, m_axis_tuser);
          check_field("byte_index", want.byte_index, m_axis_tdata[2:0]);
          check_field("data_out", want.data_out, m_axis_tdata[10:3]);
          check_field("src_pan_from_dst", want.src_pan_from_dst, m_axis_tdata[11]);
          check_field("parse_error", want.parse_error, m_axis_tdata[12]);
          check_field("frame_end", want.frame_end, m_axis_tlast);
          check_field("tdata padding", 0, m_axis_tdata[15:13]);
        end
      end
    end
    outstanding = tags_due.size();
  end

endmodule

[test/tb.sv]
// testbench top for the mac frame header parser: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb;
  import mfhp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 60;        // long receiver hold-off, fills the pipeline
  localparam int RANDOM_BYTES = 2000;
  localparam logic [1:0] AMODE_SHORT = 2'd2;
  localparam logic [1:0] KMODE_SRC4 = 2'd2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;        // [7:0] data_byte, [14:8] frame_length, [15] zero
  logic        s_axis_tuser = 1'b0;      // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;             // [2:0] byte_index, [10:3] data_out,
                                         // [11] src_pan_from_dst, [12] parse_error, zeros
  logic [3:0]  m_axis_tuser;             // field_kind
  logic        m_axis_tlast;             // frame_end

  int mismatches;
  int outstanding;

  // stimulus knobs; the receiver ones are written with nonblocking assignments
  int send_idle_pct = 15;
  int recv_idle_pct = 56;
  int hold_epoch = 0;
  int hold_served = 0;
  int hold_count = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  bit sec_setting = 1'b0;
  logic [7:0] frame_bytes[$];

  always #1 clk = ~clk;

  mac_frame_header_parser dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  byte_tag_checker checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // receiver: random backpressure, plus one long hold-off each time the epoch moves
  always @(negedge clk) begin
    if (hold_epoch != hold_served) begin
      m_axis_tready <= 1'b0;
      if (hold_count == HOLD_CYCLES - 1) begin
        hold_count <= 0;
        hold_served <= hold_epoch;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: ends the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte transfer; entered and left at a falling edge, tvalid stays high between bytes unless an idle gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic start, input logic [6:0] flen);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, flen, b};
    s_axis_tuser <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // first count bytes of frame_bytes; frame_length is noise on all but the first
  task automatic send_frame(input logic [6:0] flen, input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(frame_bytes[i], i == 0, (i == 0) ? flen : 7'($urandom_range(127)));
    end
  endtask

  // register write, only once every tagged byte has come back
  task automatic set_security(input bit en);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we <= 1'b0;
    sec_setting = en;
  endtask

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(2))
      0: return AMODE_NONE;
      1: return AMODE_SHORT;
      default: return AMODE_LONG;
    endcase
  endfunction

  function automatic int addr_len(input logic [1:0] mode);
    return (mode == AMODE_LONG) ? 8 : 2;
  endfunction

  // mostly well-formed frames with random content; some reserved modes, short
  // lengths, truncated frames and stray bytes between frames
  task automatic random_frame();
    logic [15:0] fc;
    logic [7:0] sc;
    int hdr;
    int sec_at;
    int flen;
    int nsend;
    bit secp;
    fc = 16'($urandom_range(16'hFFFF));
    fc[11:10] = pick_mode();
    fc[15:14] = pick_mode();
    if ($urandom_range(99) < 6) begin
      if ($urandom_range(1)) fc[11:10] = AMODE_RSVD;
      else fc[15:14] = AMODE_RSVD;
    end
    sc = 8'($urandom_range(255));
    hdr = 3;
    if (fc[11:10] != AMODE_NONE) hdr += 2 + addr_len(fc[11:10]);
    if (fc[15:14] != AMODE_NONE) begin
      // pan id compression drops the source pan
      if (!(fc[6] && fc[11:10] != AMODE_NONE)) hdr += 2;
      hdr += addr_len(fc[15:14]);
    end
    sec_at = hdr;
    secp = fc[3] && sec_setting;
    if (secp) begin
      case (sc[4:3])
        KMODE_NONE: hdr += 5;
        KMODE_INDEX: hdr += 6;
        KMODE_SRC4: hdr += 10;
        default: hdr += 14;
      endcase
    end
    case ($urandom_range(9))
      0: flen = hdr + 2 + $urandom_range(125 - hdr);
      1: flen = $urandom_range(hdr + 2);
      default: flen = hdr + 2 + $urandom_range(12);
    endcase
    frame_bytes.delete();
    frame_bytes.push_back(fc[7:0]);
    frame_bytes.push_back(fc[15:8]);
    while (frame_bytes.size() < flen + 2) frame_bytes.push_back(8'($urandom_range(255)));
    if (secp && sec_at < frame_bytes.size()) frame_bytes[sec_at] = sc;
    nsend = ($urandom_range(19) == 0) ? $urandom_range(flen + 1, 1) : flen + 2;
    send_frame(7'(flen), nsend);
    if ($urandom_range(15) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        send_byte(8'($urandom_range(255)), 1'b0, 7'($urandom_range(127)));
      end
    end
  endtask

  initial begin
    int target;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_security(1'b1);

    // byte outside any frame
    send_byte(8'hFF, 1'b0, 7'h7F);
    // zero length: too short for any header
    frame_bytes = '{8'h00, 8'hFF};
    send_frame(7'd0, 2);
    // reserved destination address mode
    frame_bytes = '{8'h00, 8'h04, 8'hAA, 8'h55, 8'h0F};
    send_frame(7'd3, 5);
    // longest frame abandoned by a new frame start
    frame_bytes = '{8'h41, 8'h88, 8'h01};
    send_frame(7'd127, 3);
    // pan id compression with short addresses, empty payload
    frame_bytes = '{8'h41, 8'h88, 8'h5A, 8'h34, 8'h12, 8'hCD, 8'hAB, 8'h01, 8'h00,
                    8'hEE, 8'hFF, 8'h80, 8'hC0};
    send_frame(7'd11, 13);

    set_security(1'b0);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct <= 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct <= 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      set_security(ph != 1);
      hold_epoch <= hold_epoch + 1;
      target = bytes_sent + RANDOM_BYTES / 3;
      while (bytes_sent < target) begin
        if ($urandom_range(15) == 0) set_security(1'($urandom_range(1)));
        random_frame();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
